// ===== rtl/blm_pkg.sv =====
// ----------------------------------------------------------------------------
// Block peak level meter package
// Shared types, constants and the level threshold function.
// ----------------------------------------------------------------------------
package blm_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int MAG_W        = 16;
   localparam int LEVEL_W      = 7;
   localparam int LEVEL_STEPS  = 100;
   localparam int BLOCK_LEN_W  = 16;
   localparam int POW_EXP      = 20;
   localparam int POW_W        = 320;
   localparam int SEARCH_STEPS = 16;

   localparam logic [BLOCK_LEN_W-1:0] BLOCK_LEN_RESET = 16'd4410;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_BLOCK_LEN_INDEX = 1'b0;

   typedef struct packed {
      logic [LEVEL_W-1:0] level_percent;
      logic [MAG_W-1:0]   peak_magnitude;
   } result_type;

   // Smallest magnitude p with p^20 >= 2^(3n), that is ceil(2^(0.15n)).
   // Evaluated only at elaboration, with exact integer arithmetic.
   function automatic logic [MAG_W-1:0] level_threshold(input int n);
      logic [POW_W-1:0] target;
      logic [POW_W-1:0] pw;
      logic [MAG_W:0]   lo;
      logic [MAG_W:0]   hi;
      logic [MAG_W:0]   mid;
      target = {{(POW_W-1){1'b0}}, 1'b1} << (3 * n);
      lo = 17'd1;
      hi = 17'd32768;
      for (int it = 0; it < SEARCH_STEPS; it++) begin
         if (lo < hi) begin
            mid = (lo + hi) >> 1;
            pw = {{(POW_W-1){1'b0}}, 1'b1};
            for (int k = 0; k < POW_EXP; k++) begin
               pw = pw * {{(POW_W-MAG_W-1){1'b0}}, mid};
            end
            if (pw >= target) begin
               hi = mid;
            end else begin
               lo = mid + 17'd1;
            end
         end
      end
      return lo[MAG_W-1:0];
   endfunction

endpackage

// ===== rtl/blm_fifo.sv =====
// ----------------------------------------------------------------------------
// Small register queue
// First-in first-out queue in flip-flops with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module blm_fifo #(
   parameter int WIDTH      = 16,
   parameter int DEPTH_LOG2 = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int DEPTH = 1 << DEPTH_LOG2;

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [DEPTH_LOG2:0] wr_ptr_ff, wr_ptr_in;
   logic [DEPTH_LOG2:0] rd_ptr_ff, rd_ptr_in;
   logic                do_push, do_pop;

   assign empty    = (wr_ptr_ff == rd_ptr_ff);
   assign full     = (wr_ptr_ff == {~rd_ptr_ff[DEPTH_LOG2], rd_ptr_ff[DEPTH_LOG2-1:0]});
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff[DEPTH_LOG2-1:0]];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff[DEPTH_LOG2-1:0]] <= push_data;
      end
   end

endmodule

// ===== rtl/blm_front.sv =====
// ----------------------------------------------------------------------------
// Level meter front end
// Takes samples, tracks the block peak and count, and queues the finished peak.
// ----------------------------------------------------------------------------
module blm_front import blm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [SAMPLE_W-1:0]    sample,
   input  logic                   queue_full,
   input  logic [BLOCK_LEN_W-1:0] block_len,
   output logic                   peak_push,
   output logic [MAG_W-1:0]       peak_data
);

   logic [MAG_W-1:0]       peak_ff, peak_in;
   logic [BLOCK_LEN_W-1:0] count_ff, count_in;
   logic [MAG_W-1:0]       mag;
   logic [MAG_W-1:0]       peak_max;
   logic [BLOCK_LEN_W:0]   count_next;
   logic [BLOCK_LEN_W:0]   len_full;
   logic                   accept;
   logic                   block_end;

   // A length of zero stands for 65536 samples.
   assign len_full   = {(block_len == '0), block_len};
   assign accept     = push && !queue_full;
   assign mag        = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
   assign peak_max   = (mag > peak_ff) ? mag : peak_ff;
   assign count_next = {1'b0, count_ff} + 1'b1;
   assign block_end  = (count_next >= len_full);
   assign peak_push  = accept && block_end;
   assign peak_data  = peak_max;

   always_comb begin
      peak_in  = peak_ff;
      count_in = count_ff;
      if (accept) begin
         if (block_end) begin
            peak_in  = '0;
            count_in = '0;
         end else begin
            peak_in  = peak_max;
            count_in = count_next[BLOCK_LEN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff  <= '0;
         count_ff <= '0;
      end else begin
         peak_ff  <= peak_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/blm_back.sv =====
// ----------------------------------------------------------------------------
// Level meter back end
// Compares a block peak with the level thresholds and encodes the level.
// ----------------------------------------------------------------------------
module blm_back import blm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_empty,
   input  logic [MAG_W-1:0] in_peak,
   output logic             in_pop,
   input  logic             out_full,
   output logic             out_push,
   output result_type       out_item
);

   logic                   stage_valid_ff, stage_valid_in;
   logic [LEVEL_STEPS-1:0] stage_hit_ff;
   logic [MAG_W-1:0]       stage_peak_ff;
   logic [LEVEL_STEPS-1:0] hit;
   logic                   load;
   logic [LEVEL_W-1:0]     level;

   // One comparator per threshold; the hit vector is a thermometer code.
   for (genvar g = 1; g <= LEVEL_STEPS; g++) begin : g_thresh
      localparam logic [MAG_W-1:0] THRESH = level_threshold(g);
      assign hit[g-1] = (in_peak >= THRESH);
   end

   assign out_push = stage_valid_ff && !out_full;
   assign load     = !in_empty && (!stage_valid_ff || out_push);
   assign in_pop   = load;

   // The level is the position of the top set bit of the thermometer code.
   always_comb begin
      level = '0;
      for (int n = 1; n < LEVEL_STEPS; n++) begin
         if (stage_hit_ff[n-1] && !stage_hit_ff[n]) begin
            level = level | LEVEL_W'(n);
         end
      end
      if (stage_hit_ff[LEVEL_STEPS-1]) begin
         level = level | LEVEL_W'(LEVEL_STEPS);
      end
   end

   assign out_item.level_percent  = level;
   assign out_item.peak_magnitude = stage_peak_ff;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (load) begin
         stage_valid_in = 1'b1;
      end else if (out_push) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_hit_ff  <= hit;
         stage_peak_ff <= in_peak;
      end
   end

endmodule

// ===== rtl/block_peak_log_level_meter.sv =====
// ----------------------------------------------------------------------------
// Block peak log level meter
// Measures the peak of each block of audio samples and reports a 0..100 level.
// ----------------------------------------------------------------------------
// The meter takes one signed 16-bit sample per clock cycle, with no gaps
// needed, and keeps the largest magnitude seen over a block of block_len
// samples (a value of zero means 65536). The sample that completes a block
// yields one result: the peak magnitude (0 to 32768) and the level
// floor(100*log10(peak)/log10(32768)), which is 0 for a silent block. The
// level is exact: it is the number of thresholds ceil(2^(0.15n)), n=1..100,
// that the peak reaches. The front end updates the peak and count for each
// sample; the back end does the 100 threshold compares in a registered stage
// and the level encode on the way into the result queue, so it completes
// one result per cycle while the result queue has room. A result reaches the
// rsp ports through the peak queue, the back-end stage and the result queue.
// The input side stalls only when the peak queue between front and back is
// full, which needs a stalled result side.
// ----------------------------------------------------------------------------
module block_peak_log_level_meter import blm_pkg::*; #(
   parameter int QUEUE_DEPTH_LOG2 = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   // Sample input
   input  logic                   push,
   output logic                   full,
   input  logic [SAMPLE_W-1:0]    req_sample,
   // Result output
   output logic                   empty,
   input  logic                   pop,
   output logic [LEVEL_W-1:0]     rsp_level_percent,
   output logic [MAG_W-1:0]       rsp_peak_magnitude,
   // Configuration
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready
);

   logic [BLOCK_LEN_W-1:0] block_len_ff, block_len_in;
   logic                   csr_index;
   logic                   csr_write;

   logic                   mid_push, mid_full, mid_pop, mid_empty;
   logic [MAG_W-1:0]       mid_push_data, mid_pop_data;

   logic                   out_push, out_full;
   result_type             out_item;
   logic [$bits(result_type)-1:0] out_pop_data;
   result_type             rsp_item;

   // ---------------------------------------------------------------------
   // Configuration register. Registers sit at byte address 4*index, so the
   // index is the address above the byte lane bits.
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_index = paddr[2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      block_len_in = block_len_ff;
      if (csr_write && (csr_index == CSR_BLOCK_LEN_INDEX)) begin
         block_len_in = pwdata[BLOCK_LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_len_ff <= BLOCK_LEN_RESET;
      end else begin
         block_len_ff <= block_len_in;
      end
   end

   // Reads of any index other than block_len return zero.
   assign prdata = (csr_index == CSR_BLOCK_LEN_INDEX) ?
                   {{(CSR_DATA_W-BLOCK_LEN_W){1'b0}}, block_len_ff} : '0;

   // ---------------------------------------------------------------------
   // Front end: peak tracking. The input is held off only while the peak
   // queue has no room, so a block end can always be queued.
   // ---------------------------------------------------------------------
   assign full = mid_full;

   blm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .sample     (req_sample),
      .queue_full (mid_full),
      .block_len  (block_len_ff),
      .peak_push  (mid_push),
      .peak_data  (mid_push_data)
   );

   // Queue of finished block peaks between the two halves.
   blm_fifo #(
      .WIDTH      (MAG_W),
      .DEPTH_LOG2 (QUEUE_DEPTH_LOG2)
   ) u_peak_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_push_data),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_pop_data),
      .empty     (mid_empty)
   );

   // ---------------------------------------------------------------------
   // Back end: threshold compare and level encode.
   // ---------------------------------------------------------------------
   blm_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_empty (mid_empty),
      .in_peak  (mid_pop_data),
      .in_pop   (mid_pop),
      .out_full (out_full),
      .out_push (out_push),
      .out_item (out_item)
   );

   // Result queue; its head drives the rsp ports.
   blm_fifo #(
      .WIDTH      ($bits(result_type)),
      .DEPTH_LOG2 (QUEUE_DEPTH_LOG2)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_item),
      .full      (out_full),
      .pop       (pop),
      .pop_data  (out_pop_data),
      .empty     (empty)
   );

   assign rsp_item           = result_type'(out_pop_data);
   assign rsp_level_percent  = rsp_item.level_percent;
   assign rsp_peak_magnitude = rsp_item.peak_magnitude;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // A block end is never offered to a full peak queue.
   assert property (@(posedge clock) disable iff (reset) mid_push |-> !mid_full)
      else $error("block peak dropped at full peak queue");

   // The back end only pushes a result when the result queue has room.
   assert property (@(posedge clock) disable iff (reset) out_push |-> !out_full)
      else $error("result pushed into full result queue");

   // The level never exceeds full scale.
   assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_level_percent <= LEVEL_W'(LEVEL_STEPS)))
      else $error("level above full scale");

   // A silent block reads as level zero, and a full scale peak as the top level.
   assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_peak_magnitude == '0)) |-> (rsp_level_percent == '0))
      else $error("silent block with nonzero level");

   assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_peak_magnitude == 16'd32768)) |->
      (rsp_level_percent == LEVEL_W'(LEVEL_STEPS)))
      else $error("full scale peak without top level");

   // Nothing is waiting on the result side right after reset.
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> empty)
      else $error("result queue not empty after reset");

endmodule
